// ----- sv/swbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp: shared definitions
// Default sizes, register indexes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package swbr_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int MAX_FRAMES_DEF  = 4096;
   localparam int GAIN_BITS_DEF   = 16;

   // Ramp length after reset and the field width of that register.
   localparam int FRAMES_RESET    = 1024;
   localparam int FRAMES_REG_BITS = 13;
   // Bits of the written word that the ramp length register looks at.
   localparam int FRAMES_KEEP_BITS = 20;

   localparam int CFG_INDEX_BITS = 2;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_TARGET_BALANCE = 2'd0,
      REG_TARGET_WIDTH   = 2'd1,
      REG_FRAMES         = 2'd2,
      REG_DISABLING      = 2'd3
   } reg_index_type;

   // Which ramp the shared divider works for.
   localparam logic LANE_BALANCE = 1'b0;
   localparam logic LANE_WIDTH   = 1'b1;

   typedef struct packed {
      logic accept;     // capture the incoming frame
      logic div_start;  // load the divider with the selected lane
      logic div_lane;   // lane that the divider serves
      logic init;       // buffer start: load accumulators and targets
      logic mul1;       // width gain product
      logic rebuild;    // round and rebuild left and right
      logic mul2;       // balance gain product
      logic finish;     // saturate, load the output register, advance the ramp
   } cmd_type;

   typedef struct packed {
      logic first_frame;  // frame index is zero
      logic div_done;     // divider quotient is ready
   } status_type;

endpackage
`default_nettype wire

// ----- sv/swbr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp: iterative divider
// Unsigned restoring division, one quotient bit per clock.
// ----------------------------------------------------------------------------
module swbr_div import swbr_pkg::*; #(
   parameter int NUM_BITS = 31,
   parameter int DEN_BITS = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [DEN_BITS-1:0] den,
   output logic      [NUM_BITS-1:0] quot,
   output logic                     done
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [CNT_BITS-1:0] cnt_ff;
   logic                done_ff;
   logic [NUM_BITS-1:0] work_ff, work_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS:0]   rem_sh;
   logic                take;

   // The remainder stays below the divisor, so the shifted value fits one extra bit.
   assign rem_sh  = {rem_ff, work_ff[NUM_BITS-1]};
   assign take    = rem_sh >= {1'b0, den};
   assign rem_in  = take ? DEN_BITS'(rem_sh - {1'b0, den}) : rem_sh[DEN_BITS-1:0];
   assign work_in = {work_ff[NUM_BITS-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_BITS'(1)) && !start;
         if (start) begin
            cnt_ff <= CNT_BITS'(NUM_BITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= num;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign quot = work_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ----- sv/swbr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp: datapath
// Configuration registers, ramp state, gain arithmetic and the output register.
// ----------------------------------------------------------------------------
module swbr_dp import swbr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int GAIN_BITS   = GAIN_BITS_DEF,
   localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int CSR_BITS   = (GAIN_BITS > FRAMES_REG_BITS) ? GAIN_BITS : FRAMES_REG_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [DATA_BITS-1:0]      req_tdata,
   input  wire logic                      csr_wr_en,
   input  wire logic [CFG_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_wdata,
   output logic      [DATA_BITS-1:0]      rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int S         = SAMPLE_BITS;
   localparam int GB        = GAIN_BITS;
   localparam int G         = GAIN_BITS - 1;
   localparam int ACC_BITS  = 2 * G + 1;
   localparam int STEP_BITS = 2 * G + 2;
   localparam int NUM_BITS  = GB + G;
   localparam int NB        = $clog2(MAX_FRAMES + 1);
   localparam int FB        = $clog2(MAX_FRAMES);
   localparam int KEEP_BITS = (CSR_BITS < FRAMES_KEEP_BITS) ? CSR_BITS : FRAMES_KEEP_BITS;
   localparam int CMP_BITS  = (KEEP_BITS > NB) ? KEEP_BITS : NB;
   localparam int FR_RESET  = (FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RESET;
   localparam int P1_BITS   = S + G + 3;
   localparam int P2_BITS   = S + G + 4;

   localparam logic signed [GB:0]        GONE     = {2'b01, {G{1'b0}}};
   localparam logic signed [STEP_BITS:0] SUM_MAX  =
      (STEP_BITS+1)'((64'sd1 <<< (2 * G)) - 64'sd1);
   localparam logic signed [STEP_BITS:0] SUM_MIN  = (STEP_BITS+1)'(-(64'sd1 <<< (2 * G)));
   localparam logic signed [P1_BITS-1:0] P1_HALF  = P1_BITS'(64'd1 << (G - 1));
   localparam logic signed [P2_BITS-1:0] P2_HALF  = P2_BITS'(64'd1 << G);
   localparam logic signed [S+2:0]       OUT_MAX  = (S+3)'((64'sd1 <<< (S - 1)) - 64'sd1);
   localparam logic signed [S+2:0]       OUT_MIN  = (S+3)'(-(64'sd1 <<< (S - 1)));

   // Gain coefficient: 1-g for a cutting positive gain, 1+g otherwise.
   function automatic logic [G:0] coef(input logic signed [GB-1:0] g, input logic pos);
      logic signed [GB:0] gx;
      logic signed [GB:0] r;
      gx = {g[GB-1], g};
      r  = pos ? (GONE - gx) : (GONE + gx);
      return r[G:0];
   endfunction

   function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [STEP_BITS:0] v);
      if (v > SUM_MAX) begin
         return SUM_MAX[ACC_BITS-1:0];
      end else if (v < SUM_MIN) begin
         return SUM_MIN[ACC_BITS-1:0];
      end
      return v[ACC_BITS-1:0];
   endfunction

   function automatic logic [S-1:0] sat_out(input logic signed [S+2:0] v);
      if (v > OUT_MAX) begin
         return OUT_MAX[S-1:0];
      end else if (v < OUT_MIN) begin
         return OUT_MIN[S-1:0];
      end
      return v[S-1:0];
   endfunction

   // Configuration registers.
   logic signed [GB-1:0] target_b_ff, target_w_ff;
   logic [NB-1:0]        frames_ff, frames_in;
   logic                 disabling_ff;
   logic [CMP_BITS-1:0]  fr_val;

   // Ramp state.
   logic signed [GB-1:0]        prev_b_ff, prev_w_ff;
   logic signed [ACC_BITS-1:0]  acc_b_ff, acc_w_ff;
   logic signed [STEP_BITS-1:0] step_b_ff, step_w_ff;
   logic [FB-1:0]               index_ff;

   // Frame pipeline registers.
   logic signed [S:0]         m2_ff, s2_ff;
   logic signed [P1_BITS-1:0] p1_ff, p1_in;
   logic                      gw_pos_ff, gb_pos_ff;
   logic [G:0]                cb_ff;
   logic signed [S+1:0]       l2_ff, r2_ff, l2_in, r2_in;
   logic signed [P2_BITS-1:0] p2_ff, p2_in;
   logic [S-1:0]              left_ff, right_ff, left_in, right_in;
   logic                      last_ff;

   assign fr_val    = CMP_BITS'(csr_wdata[KEEP_BITS-1:0]);
   assign frames_in = (fr_val == '0) ? NB'(1) :
                      (fr_val > CMP_BITS'(MAX_FRAMES)) ? NB'(MAX_FRAMES) : fr_val[NB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_b_ff  <= '0;
         target_w_ff  <= '0;
         frames_ff    <= NB'(FR_RESET);
         disabling_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_BALANCE: target_b_ff  <= csr_wdata[GB-1:0];
            REG_TARGET_WIDTH:   target_w_ff  <= csr_wdata[GB-1:0];
            REG_FRAMES:         frames_ff    <= frames_in;
            REG_DISABLING:      disabling_ff <= csr_wdata[0];
            default:            ;
         endcase
      end
   end

   // Buffer-start targets and the step divisions.
   logic signed [GB-1:0]        tb, tw;
   logic signed [GB:0]          diff_b, diff_w, diff_sel, mag;
   logic                        neg_sel;
   logic [NUM_BITS-1:0]         div_num, div_quot;
   logic                        div_done;
   logic signed [STEP_BITS-1:0] step_val;

   assign tb       = disabling_ff ? '0 : target_b_ff;
   assign tw       = disabling_ff ? '0 : target_w_ff;
   assign diff_b   = {tb[GB-1], tb} - {prev_b_ff[GB-1], prev_b_ff};
   assign diff_w   = {tw[GB-1], tw} - {prev_w_ff[GB-1], prev_w_ff};
   assign diff_sel = (cmd.div_lane == LANE_WIDTH) ? diff_w : diff_b;
   assign neg_sel  = diff_sel[GB];
   assign mag      = neg_sel ? -diff_sel : diff_sel;
   assign div_num  = {mag[GB-1:0], {G{1'b0}}};
   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign step_val = neg_sel ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

   swbr_div #(
      .NUM_BITS(NUM_BITS),
      .DEN_BITS(NB)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num  (div_num),
      .den  (frames_ff),
      .quot (div_quot),
      .done (div_done)
   );

   // Gains for the current frame; the last frame of a buffer lands exactly on target.
   logic [NB:0]                 index_cmp;
   logic                        last;
   logic signed [GB-1:0]        gb, gw;
   logic                        gb_pos, gw_pos;
   logic [G:0]                  cw;
   logic signed [S:0]           sel1;
   logic signed [ACC_BITS-1:0]  base_b, base_w;
   logic signed [STEP_BITS:0]   sum_b, sum_w;

   assign index_cmp = (NB+1)'(index_ff) + (NB+1)'(1);
   assign last      = index_cmp >= {1'b0, frames_ff};
   assign gb        = last ? prev_b_ff : acc_b_ff[ACC_BITS-1:G];
   assign gw        = last ? prev_w_ff : acc_w_ff[ACC_BITS-1:G];
   assign gb_pos    = !gb[GB-1] && (gb != '0);
   assign gw_pos    = !gw[GB-1] && (gw != '0);
   assign cw        = coef(gw, gw_pos);
   assign sel1      = gw_pos ? m2_ff : s2_ff;
   assign p1_in     = sel1 * $signed({1'b0, cw});

   assign base_b = cmd.init ? $signed({prev_b_ff, {G{1'b0}}}) : acc_b_ff;
   assign base_w = cmd.init ? $signed({prev_w_ff, {G{1'b0}}}) : acc_w_ff;
   assign sum_b  = {{2{base_b[ACC_BITS-1]}}, base_b} + {step_b_ff[STEP_BITS-1], step_b_ff};
   assign sum_w  = {{2{base_w[ACC_BITS-1]}}, base_w} + {step_w_ff[STEP_BITS-1], step_w_ff};

   // Rebuild left and right from the scaled mid or side.
   logic signed [P1_BITS-1:0] r1_full;
   logic signed [S:0]         r1, m2x, s2x;

   assign r1_full = (p1_ff + P1_HALF) >>> G;
   assign r1      = r1_full[S:0];
   assign m2x     = gw_pos_ff ? r1 : m2_ff;
   assign s2x     = gw_pos_ff ? s2_ff : r1;
   assign l2_in   = {m2x[S], m2x} - {s2x[S], s2x};
   assign r2_in   = {m2x[S], m2x} + {s2x[S], s2x};

   logic signed [S+1:0] sel2;
   assign sel2  = gb_pos_ff ? l2_ff : r2_ff;
   assign p2_in = sel2 * $signed({1'b0, cb_ff});

   // Final rounding: the balance-scaled side drops G+1 bits, the other side one bit.
   logic signed [P2_BITS-1:0] sc_full;
   logic signed [S+2:0]       scaled, half_l, half_r, l2_ext, r2_ext;

   assign sc_full  = (p2_ff + P2_HALF) >>> (G + 1);
   assign scaled   = sc_full[S+2:0];
   assign l2_ext   = {l2_ff[S+1], l2_ff};
   assign r2_ext   = {r2_ff[S+1], r2_ff};
   assign half_l   = (l2_ext + $signed((S+3)'(1))) >>> 1;
   assign half_r   = (r2_ext + $signed((S+3)'(1))) >>> 1;
   assign left_in  = sat_out(gb_pos_ff ? scaled : half_l);
   assign right_in = sat_out(gb_pos_ff ? half_r : scaled);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_b_ff <= '0;
         prev_w_ff <= '0;
         acc_b_ff  <= '0;
         acc_w_ff  <= '0;
         step_b_ff <= '0;
         step_w_ff <= '0;
         index_ff  <= '0;
      end else begin
         if (div_done) begin
            if (cmd.div_lane == LANE_WIDTH) begin
               step_w_ff <= step_val;
            end else begin
               step_b_ff <= step_val;
            end
         end
         if (cmd.init) begin
            acc_b_ff  <= sat_acc(sum_b);
            acc_w_ff  <= sat_acc(sum_w);
            prev_b_ff <= tb;
            prev_w_ff <= tw;
         end
         if (cmd.finish) begin
            if (last) begin
               index_ff <= '0;
            end else begin
               index_ff <= index_ff + FB'(1);
               acc_b_ff <= sat_acc(sum_b);
               acc_w_ff <= sat_acc(sum_w);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         m2_ff <= {req_tdata[S-1], req_tdata[S-1:0]} + {req_tdata[2*S-1], req_tdata[2*S-1:S]};
         s2_ff <= {req_tdata[2*S-1], req_tdata[2*S-1:S]} - {req_tdata[S-1], req_tdata[S-1:0]};
      end
      if (cmd.mul1) begin
         p1_ff     <= p1_in;
         gw_pos_ff <= gw_pos;
         gb_pos_ff <= gb_pos;
         cb_ff     <= coef(gb, gb_pos);
      end
      if (cmd.rebuild) begin
         l2_ff <= l2_in;
         r2_ff <= r2_in;
      end
      if (cmd.mul2) begin
         p2_ff <= p2_in;
      end
      if (cmd.finish) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         last_ff  <= last;
      end
   end

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[S-1:0]   = left_ff;
      rsp_tdata[2*S-1:S] = right_ff;
   end

   assign rsp_tlast          = last_ff;
   assign status.first_frame = (index_ff == '0);
   assign status.div_done    = div_done;

endmodule
`default_nettype wire

// ----- sv/swbr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp: controller
// Sequences one frame through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module swbr_ctrl import swbr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVB_GO,
      ST_DIVB_WAIT,
      ST_DIVW_GO,
      ST_DIVW_WAIT,
      ST_INIT,
      ST_MUL1,
      ST_REBUILD,
      ST_MUL2,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.first_frame ? ST_DIVB_GO : ST_MUL1;
            end
         end
         ST_DIVB_GO:   state_in = ST_DIVB_WAIT;
         ST_DIVB_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DIVW_GO;
            end
         end
         ST_DIVW_GO:   state_in = ST_DIVW_WAIT;
         ST_DIVW_WAIT: begin
            if (status.div_done) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:      state_in = ST_MUL1;
         ST_MUL1:      state_in = ST_REBUILD;
         ST_REBUILD:   state_in = ST_MUL2;
         ST_MUL2:      state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.div_start = (state_ff == ST_DIVB_GO) || (state_ff == ST_DIVW_GO);
      cmd.div_lane  = ((state_ff == ST_DIVW_GO) || (state_ff == ST_DIVW_WAIT)) ?
                      LANE_WIDTH : LANE_BALANCE;
      cmd.init      = (state_ff == ST_INIT);
      cmd.mul1      = (state_ff == ST_MUL1);
      cmd.rebuild   = (state_ff == ST_REBUILD);
      cmd.mul2      = (state_ff == ST_MUL2);
      cmd.finish    = (state_ff == ST_FINISH) && slot_free;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- sv/stereo_width_balance_ramp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp
// Mid/side width control and left/right balance with per-frame gain ramps.
// ----------------------------------------------------------------------------
// Usage: one stereo frame enters per req_ transaction and one processed frame
// leaves per rsp_ transaction; rsp_tlast marks the last frame of a ramp buffer.
// Registers are to be written on csr_ only while no frame is in flight; the
// block itself does not enforce this. New targets take effect at the next
// buffer start; a new ramp length does too, and also moves the end of the
// current buffer. After acceptance a frame passes the MUL1, REBUILD, MUL2 and
// FINISH states, and the next frame is taken once idle again. The first frame
// of each buffer first runs the per-frame step division for both ramps through
// one shared bit-serial divider, which forms a 2*GAIN_BITS-1 bit quotient each.
// The block holds one frame at a time. The output register lets a new frame be
// accepted while the previous result still waits; if the receiver stalls, the
// next result is held in the datapath and the block takes no further frame.
// Reset clears the ramp state and the output valid flag and restores the
// register defaults (no width or balance change, 1024-frame ramps).
// ----------------------------------------------------------------------------
module stereo_width_balance_ramp import swbr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int GAIN_BITS   = GAIN_BITS_DEF,
   localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int CSR_BITS   = (GAIN_BITS > FRAMES_REG_BITS) ? GAIN_BITS : FRAMES_REG_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [DATA_BITS-1:0]      req_tdata,  // left_in, right_in
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [DATA_BITS-1:0]      rsp_tdata,  // left_out, right_out
   output logic                           rsp_tlast,  // buffer_end
   input  wire logic                      csr_wr_en,
   input  wire logic [CFG_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // The controller steps each frame through the datapath and drives req_tready and rsp_tvalid.
   swbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the ramps, the divider and the output register.
   swbr_dp #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_FRAMES (MAX_FRAMES),
      .GAIN_BITS  (GAIN_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_tdata(req_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- sv/swbr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo width and balance ramp: port checker
// Properties of the top-level handshakes, attached by bind.
// ----------------------------------------------------------------------------
module swbr_checker import swbr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [DATA_BITS-1:0] rsp_tdata,
   input wire logic                 rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A frame needs several datapath steps, so no result appears right after acceptance.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after acceptance");

   // A result is published as the controller returns to accepting frames.
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("new result without the input side ready");

endmodule

bind stereo_width_balance_ramp swbr_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_swbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo width and balance ramp testbench
// Sends stereo frames through the block under changing width, balance, ramp
// length and disable settings. A behavioral model of the gain ramps and of the
// mid/side and balance arithmetic predicts every result, which is checked
// field by field against the block's output stream.
// ----------------------------------------------------------------------------
module tb;
   import swbr_pkg::*;

   localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
   localparam int GF        = GAIN_BITS_DEF - 1;
   localparam longint G_ONE = longint'(1) << GF;
   // Ramp accumulators live in Q1.(2*GF) and saturate to [-1, 1).
   localparam longint ACC_MAX = (longint'(1) << (2 * GF)) - 1;
   localparam longint ACC_MIN = -(longint'(1) << (2 * GF));
   localparam longint SMP_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SMP_MIN = -(longint'(1) << (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'h800000;
   // Minimum number of random frames to send after the directed part.
   localparam int FRAME_TOTAL = 1150;
   // Cycles without any transaction before the run is declared hung. The slowest
   // correct gap is a buffer start plus the long receiver hold-off (LONG_HOLD)
   // plus the longest sender gap, so this leaves ample margin.
   localparam int HANG_LIMIT = 4000;
   localparam int LONG_HOLD  = 300;

   // One stereo frame as it sits in tdata: left in the low bits, right above.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left;
   } stereo_pair_type;

   typedef struct packed {
      logic            last;
      stereo_pair_type pair;
   } mixed_frame_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [2*SAMPLE_W-1:0]      req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [2*SAMPLE_W-1:0]      rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_wr_en = 1'b0;
   reg_index_type              csr_index = REG_TARGET_BALANCE;
   logic [GAIN_BITS_DEF-1:0]   csr_wdata = '0;

   stereo_width_balance_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // left_in, right_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // left_out, right_out
      .rsp_tlast  (rsp_tlast),   // buffer_end
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral model state. The register copies are updated at the moment the
   // configuration write is issued, which is safe because writes only happen
   // while no frame is in flight.
   // ------------------------------------------------------------------------
   logic signed [GAIN_BITS_DEF-1:0] tgt_balance = '0;
   logic signed [GAIN_BITS_DEF-1:0] tgt_width   = '0;
   logic [GAIN_BITS_DEF-1:0]        ramp_len    = GAIN_BITS_DEF'(FRAMES_RESET);
   logic                            ramp_off    = 1'b0;
   longint bal_prev = 0, wid_prev = 0;
   longint bal_acc = 0, wid_acc = 0;
   longint bal_step = 0, wid_step = 0;
   int     frame_pos = 0;

   stereo_pair_type pending_pairs[$];   // frames waiting to be offered
   mixed_frame_type awaited_frames[$];  // predicted results, oldest first
   int  fail_count = 0;
   bit  req_fired = 1'b0;            // set at the edge where a req_ transaction completes
   bit  sender_gaps = 1'b0;
   bit  receiver_gaps = 1'b0;
   bit  hold_request = 1'b0;         // asks the receiver for one long hold-off
   int  req_gap = 0;
   int  rsp_wait = 0;
   int  idle_cycles = 0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Round half up, then shift right by k with floor semantics.
   function automatic longint round_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   // Computes the processed frame for one accepted input and advances the ramps.
   function automatic mixed_frame_type mix_frame(stereo_pair_type x);
      longint span, tb, tw, acc_b, acc_w, gb, gw, m2, s2, l2, r2, lo, ro;
      logic   last_f;
      mixed_frame_type res;
      span = longint'(ramp_len);
      if (span == 0) span = 1;
      if (span > MAX_FRAMES_DEF) span = MAX_FRAMES_DEF;
      // At a buffer start the new targets are latched and the per-frame steps
      // are derived from the distance to travel.
      if (frame_pos == 0) begin
         tb = ramp_off ? 0 : longint'(tgt_balance);
         tw = ramp_off ? 0 : longint'(tgt_width);
         bal_step = ((tb - bal_prev) * G_ONE) / span;
         wid_step = ((tw - wid_prev) * G_ONE) / span;
         bal_acc  = clamp(bal_prev * G_ONE + bal_step, ACC_MIN, ACC_MAX);
         wid_acc  = clamp(wid_prev * G_ONE + wid_step, ACC_MIN, ACC_MAX);
         bal_prev = tb;
         wid_prev = tw;
      end
      // The last frame of a buffer lands exactly on the target gains.
      last_f = (frame_pos + 1 >= span);
      acc_b  = last_f ? bal_prev * G_ONE : bal_acc;
      acc_w  = last_f ? wid_prev * G_ONE : wid_acc;
      gb = acc_b >>> GF;
      gw = acc_w >>> GF;
      m2 = longint'(x.left) + longint'(x.right);
      s2 = longint'(x.right) - longint'(x.left);
      if (gw > 0) m2 = round_shift(m2 * (G_ONE - gw), GF);
      else        s2 = round_shift(s2 * (G_ONE + gw), GF);
      l2 = m2 - s2;
      r2 = m2 + s2;
      if (gb > 0) begin
         lo = round_shift(l2 * (G_ONE - gb), GF + 1);
         ro = round_shift(r2, 1);
      end else begin
         lo = round_shift(l2, 1);
         ro = round_shift(r2 * (G_ONE + gb), GF + 1);
      end
      res.pair.left  = SAMPLE_W'(clamp(lo, SMP_MIN, SMP_MAX));
      res.pair.right = SAMPLE_W'(clamp(ro, SMP_MIN, SMP_MAX));
      res.last       = last_f;
      if (last_f) begin
         frame_pos = 0;
      end else begin
         frame_pos++;
         bal_acc = clamp(bal_acc + bal_step, ACC_MIN, ACC_MAX);
         wid_acc = clamp(wid_acc + wid_step, ACC_MIN, ACC_MAX);
      end
      return res;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 7))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return SAMPLE_W'($signed(raw[5:0]) - 32);
         default: return raw[SAMPLE_W-1:0];
      endcase
   endfunction

   // Random frames, with a share of mono and anti-phase pairs that put all the
   // energy into mid or into side.
   function automatic stereo_pair_type draw_pair();
      stereo_pair_type p;
      p.left = draw_sample();
      case ($urandom_range(0, 9))
         0:       p.right = p.left;
         1:       p.right = -p.left;
         default: p.right = draw_sample();
      endcase
      return p;
   endfunction

   function automatic logic [GAIN_BITS_DEF-1:0] draw_gain();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return '0;
         default: return raw[GAIN_BITS_DEF-1:0];
      endcase
   endfunction

   // Ramp lengths are mostly short so that buffer starts come often; zero and
   // out-of-range values exercise the clamping of the length.
   function automatic logic [GAIN_BITS_DEF-1:0] draw_span();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 19))
         0:          return '0;
         1:          return GAIN_BITS_DEF'(MAX_FRAMES_DEF);
         2:          return raw[GAIN_BITS_DEF-1:0];
         3, 4, 5, 6: return GAIN_BITS_DEF'($urandom_range(9, 64));
         default:    return GAIN_BITS_DEF'($urandom_range(1, 8));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender: offers queued frames at the falling edge. The next value of valid
   // is worked out first and assigned once, so a valid that stays high for a
   // back-to-back frame never gets two updates in one step.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic                  next_valid;
      logic [2*SAMPLE_W-1:0] next_data;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_fired) begin
            req_fired  = 1'b0;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_pairs.size() > 0) begin
               next_data  = pending_pairs.pop_front();
               next_valid = 1'b1;
               req_gap    = pick_gap(sender_gaps);
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Receiver: random stalls, plus one long hold-off on request. The hold-off is
   // counted here so that the sender keeps offering frames while the block
   // backs up and drops req_tready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_wait     = LONG_HOLD;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_wait   = pick_gap(receiver_gaps);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge, an accepted input frame is run through the
   // model and its prediction queued; an accepted result is compared with the
   // oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      stereo_pair_type got;
      mixed_frame_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            awaited_frames.push_back(mix_frame(stereo_pair_type'(req_tdata)));
            req_fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = stereo_pair_type'(rsp_tdata);
            if (awaited_frames.size() == 0) begin
               $error("rsp transaction with no frame outstanding");
               fail_count++;
            end else begin
               want = awaited_frames.pop_front();
               if (got.left !== want.pair.left) begin
                  $error("left_out: expected %0d, got %0d", want.pair.left, got.left);
                  fail_count++;
               end
               if (got.right !== want.pair.right) begin
                  $error("right_out: expected %0d, got %0d", want.pair.right, got.right);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("buffer_end: expected %0b, got %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: any transaction or register write restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("stereo_width_balance_ramp test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------

   // Writes one register and mirrors it into the model.
   task automatic write_reg(reg_index_type idx, logic [GAIN_BITS_DEF-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_TARGET_BALANCE: tgt_balance = value;
         REG_TARGET_WIDTH:   tgt_width   = value;
         REG_FRAMES:         ramp_len    = value;
         REG_DISABLING:      ramp_off    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      stereo_pair_type p;
      p.left  = l;
      p.right = r;
      pending_pairs.push_back(p);
   endtask

   // Waits until every queued frame was taken and every result came back.
   // Each frame yields a result, so the block is idle at that point.
   task automatic drain();
      @(posedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || awaited_frames.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int sent;
      int count;
      int phase;
      logic [31:0] raw;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: unity gains over a 1024-frame buffer, so the output must
      // equal the input, including full-scale and opposite-polarity frames.
      add_pair(S_MAX, S_MAX);
      add_pair(S_MIN, S_MIN);
      add_pair(S_MAX, S_MIN);
      add_pair(S_MIN, S_MAX);
      drain();
      // Shortening the ramp below the current position ends the buffer on the
      // very next frame.
      write_reg(REG_FRAMES, 16'd2);
      @(posedge clock);
      add_pair('0, '0);
      add_pair(-24'sd1, 24'sd1);
      drain();

      // Single-frame buffers jump straight to the extremes: full left cut and
      // full side removal.
      write_reg(REG_TARGET_BALANCE, 16'h7FFF);
      write_reg(REG_TARGET_WIDTH, 16'h8000);
      write_reg(REG_FRAMES, 16'd1);
      @(posedge clock);
      add_pair(S_MAX, S_MIN);
      add_pair(S_MIN, S_MAX);
      add_pair(S_MAX, S_MAX);
      drain();

      // Opposite extremes; a ramp length of zero behaves as one.
      write_reg(REG_TARGET_BALANCE, 16'h8000);
      write_reg(REG_TARGET_WIDTH, 16'h7FFF);
      write_reg(REG_FRAMES, 16'd0);
      @(posedge clock);
      add_pair(S_MAX, S_MIN);
      add_pair(S_MIN, S_MIN);
      add_pair(24'sd3, -24'sd5);
      drain();

      // Disabling ramps both gains back to zero; the other written bits are
      // ignored.
      write_reg(REG_DISABLING, 16'hFFFF);
      write_reg(REG_FRAMES, 16'd2);
      @(posedge clock);
      add_pair(S_MIN, S_MAX);
      add_pair(S_MAX, S_MIN);
      add_pair(24'sd12345, -24'sd777);
      drain();

      // A ramp length past the maximum clamps to it; then the length drops
      // below the frames already played mid-buffer.
      write_reg(REG_DISABLING, 16'h0000);
      write_reg(REG_FRAMES, 16'hFFFF);
      @(posedge clock);
      add_pair(S_MAX, S_MIN);
      add_pair(S_MIN, S_MAX);
      add_pair(S_MAX, S_MAX);
      add_pair(-24'sd1, -24'sd1);
      drain();
      write_reg(REG_FRAMES, 16'd3);
      @(posedge clock);
      add_pair(S_MIN, S_MIN);
      add_pair(S_MAX, S_MIN);

      // Random phases: new settings between phases, random frames within.
      sent  = 0;
      phase = 0;
      while (sent < FRAME_TOTAL) begin
         drain();
         if ($urandom_range(0, 1)) write_reg(REG_TARGET_BALANCE, draw_gain());
         if ($urandom_range(0, 1)) write_reg(REG_TARGET_WIDTH, draw_gain());
         if ($urandom_range(0, 1)) write_reg(REG_FRAMES, draw_span());
         if ($urandom_range(0, 3) == 0) begin
            raw    = $urandom();
            raw[0] = ($urandom_range(0, 3) == 0);
            write_reg(REG_DISABLING, raw[GAIN_BITS_DEF-1:0]);
         end
         @(posedge clock);
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         count = $urandom_range(5, 60);
         if (phase == 3) begin
            // Back-pressure check: the receiver holds off while the sender
            // streams without gaps, so the block fills and stalls its input.
            sender_gaps  = 1'b0;
            count        = 80;
            hold_request = 1'b1;
         end
         repeat (count) pending_pairs.push_back(draw_pair());
         sent += count;
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (awaited_frames.size() != 0) begin
         $error("%0d predicted frames never came out", awaited_frames.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("stereo_width_balance_ramp test passed");
      else
         $display("stereo_width_balance_ramp test failed");
      $finish;
   end

endmodule
